// ===== src/qvr_pkg.sv =====
// qvr_pkg: shared constants and types for the quaternion vector rotator.
// No dependencies; imported by every module under src.
package qvr_pkg;

    // default widths
    localparam int QVR_VEC_BITS       = 16;
    localparam int QVR_QUAT_FRAC_BITS = 14;
    localparam int QVR_OUT_BITS       = 17;
    localparam int QVR_QUEUE_DEPTH    = 4;

    // quaternion product slots carried from front to back
    localparam int NUM_PROD = 9;
    localparam int IDX_II   = 0;
    localparam int IDX_JJ   = 1;
    localparam int IDX_KK   = 2;
    localparam int IDX_IJ   = 3;
    localparam int IDX_IK   = 4;
    localparam int IDX_JK   = 5;
    localparam int IDX_IR   = 6;
    localparam int IDX_JR   = 7;
    localparam int IDX_KR   = 8;

    // queue status seen by both neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } qvr_qstat_t;

endpackage

// ===== src/quaternion_vector_rotate_top.sv =====
// quaternion_vector_rotate_top: quaternion rotation of a 3D vector, fixed point.
// Depends on qvr_pkg, qvr_front, qvr_queue and qvr_back.
//
//  channel  | handshake    | transfer when   | payload
//  ---------+--------------+-----------------+-----------------------------------------
//  input    | push / full  | push && !full   | vec_x vec_y vec_z quat_r quat_i quat_j quat_k
//  result   | pop / empty  | pop && !empty   | rot_x rot_y rot_z
//
// One item per cycle sustained while results are popped; an input transfer passes the front
// stage, the queue, then five back stages (coefficient add, round/clamp, multiply, row sum,
// saturate), the last of which holds the result.
// Reset clears all valid flags and queue pointers; no clearing pass is needed.
// A stalled result port backs up the back stages, then the queue, then full rises;
// full depends only on registered state (front stage valid, queue count), not on pop.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
#(
    parameter int VEC_BITS       = QVR_VEC_BITS,
    parameter int QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS,
    parameter int QUEUE_DEPTH    = QVR_QUEUE_DEPTH,
    localparam int QB            = QUAT_FRAC_BITS + 2,
    localparam int DW            = NUM_PROD * 2 * QB + 3 * VEC_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic signed [VEC_BITS-1:0]     vec_x,
    input  logic signed [VEC_BITS-1:0]     vec_y,
    input  logic signed [VEC_BITS-1:0]     vec_z,
    input  logic signed [QB-1:0]           quat_r,
    input  logic signed [QB-1:0]           quat_i,
    input  logic signed [QB-1:0]           quat_j,
    input  logic signed [QB-1:0]           quat_k,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [QVR_OUT_BITS-1:0] rot_x,
    output logic signed [QVR_OUT_BITS-1:0] rot_y,
    output logic signed [QVR_OUT_BITS-1:0] rot_z
);

    qvr_qstat_t    qstat;
    logic          q_push;
    logic          q_pop;
    logic [DW-1:0] q_wr_data;
    logic [DW-1:0] q_rd_data;

    qvr_front #(
        .VEC_BITS       (VEC_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .vec_x  (vec_x),
        .vec_y  (vec_y),
        .vec_z  (vec_z),
        .quat_r (quat_r),
        .quat_i (quat_i),
        .quat_j (quat_j),
        .quat_k (quat_k),
        .qstat  (qstat),
        .q_push (q_push),
        .q_data (q_wr_data)
    );

    qvr_queue #(
        .DW    (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (qstat)
    );

    qvr_back #(
        .VEC_BITS       (VEC_BITS),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .q_data (q_rd_data),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .rot_x  (rot_x),
        .rot_y  (rot_y),
        .rot_z  (rot_z)
    );

endmodule

// ===== src/qvr_front.sv =====
// qvr_front: input stage; takes a transfer and forms the nine quaternion products.
// Depends on qvr_pkg; feeds qvr_queue.
module qvr_front
    import qvr_pkg::*;
#(
    parameter int VEC_BITS       = QVR_VEC_BITS,
    parameter int QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS,
    localparam int QB            = QUAT_FRAC_BITS + 2,
    localparam int PW            = 2 * QB,
    localparam int DW            = NUM_PROD * PW + 3 * VEC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [VEC_BITS-1:0] vec_x,
    input  logic signed [VEC_BITS-1:0] vec_y,
    input  logic signed [VEC_BITS-1:0] vec_z,
    input  logic signed [QB-1:0]       quat_r,
    input  logic signed [QB-1:0]       quat_i,
    input  logic signed [QB-1:0]       quat_j,
    input  logic signed [QB-1:0]       quat_k,
    input  qvr_qstat_t                 qstat,
    output logic                       q_push,
    output logic [DW-1:0]              q_data
);

    logic          valid_reg;
    logic          valid_next;
    logic          stage_ready;
    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    logic signed [PW-1:0] prod [NUM_PROD];

    // stage drains into the queue whenever the queue has room
    assign stage_ready = !valid_reg || !qstat.full;
    assign full        = !stage_ready;
    assign q_push      = valid_reg && !qstat.full;
    assign q_data      = data_reg;

    // products of quaternion parts
    always_comb
    begin
        prod[IDX_II] = PW'(quat_i) * PW'(quat_i);
        prod[IDX_JJ] = PW'(quat_j) * PW'(quat_j);
        prod[IDX_KK] = PW'(quat_k) * PW'(quat_k);
        prod[IDX_IJ] = PW'(quat_i) * PW'(quat_j);
        prod[IDX_IK] = PW'(quat_i) * PW'(quat_k);
        prod[IDX_JK] = PW'(quat_j) * PW'(quat_k);
        prod[IDX_IR] = PW'(quat_i) * PW'(quat_r);
        prod[IDX_JR] = PW'(quat_j) * PW'(quat_r);
        prod[IDX_KR] = PW'(quat_k) * PW'(quat_r);
    end

    // pack products then vector
    always_comb
    begin
        data_next = '0;
        for (int n = 0; n < NUM_PROD; n++)
        begin
            data_next[n*PW +: PW] = prod[n];
        end
        data_next[NUM_PROD*PW +: VEC_BITS]              = vec_x;
        data_next[NUM_PROD*PW + VEC_BITS +: VEC_BITS]   = vec_y;
        data_next[NUM_PROD*PW + 2*VEC_BITS +: VEC_BITS] = vec_z;
    end

    assign valid_next = stage_ready ? push : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== src/qvr_queue.sv =====
// qvr_queue: short FIFO between the product front and the matrix back end.
// Depends on qvr_pkg for the status struct and the default depth.
module qvr_queue
    import qvr_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = QVR_QUEUE_DEPTH,
    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wr_data,
    input  logic          pop,
    output logic [DW-1:0] rd_data,
    output qvr_qstat_t    stat
);

    logic [DW-1:0]   store_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg;
    logic [PTRW-1:0] wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;

    assign stat.full  = (count_reg == CNTW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = store_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("queue occupancy beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");
`endif

endmodule

// ===== src/qvr_back.sv =====
// qvr_back: coefficient rounding, matrix-vector product and output saturation.
// Depends on qvr_pkg; drains qvr_queue and drives the result ports.
module qvr_back
    import qvr_pkg::*;
#(
    parameter int VEC_BITS       = QVR_VEC_BITS,
    parameter int QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS,
    localparam int F             = QUAT_FRAC_BITS,
    localparam int QB            = F + 2,
    localparam int PW            = 2 * QB,
    localparam int DW            = NUM_PROD * PW + 3 * VEC_BITS,
    localparam int CW            = PW + 2,
    localparam int SHW           = CW - F,
    localparam int MW            = QB + VEC_BITS,
    localparam int AW            = MW + 2,
    localparam int RW            = AW - F,
    localparam int NST           = 5
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  qvr_qstat_t                     qstat,
    input  logic [DW-1:0]                  q_data,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic signed [QVR_OUT_BITS-1:0] rot_x,
    output logic signed [QVR_OUT_BITS-1:0] rot_y,
    output logic signed [QVR_OUT_BITS-1:0] rot_z
);

    localparam logic [CW-1:0] HALF_C     = CW'(1) << (F - 1);
    localparam logic [CW-1:0] ONE_HALF_C = (CW'(1) << (2 * F)) | HALF_C;
    localparam logic [AW-1:0] HALF_A     = AW'(1) << (F - 1);

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] rdy;

    logic [CW-1:0]        pe [NUM_PROD];
    logic [VEC_BITS-1:0]  vin [3];

    logic [CW-1:0]              raw_reg  [NUM_PROD];
    logic [CW-1:0]              raw_next [NUM_PROD];
    logic [VEC_BITS-1:0]        v1_reg   [3];
    logic signed [QB-1:0]       coef_reg  [NUM_PROD];
    logic signed [QB-1:0]       coef_next [NUM_PROD];
    logic signed [VEC_BITS-1:0] v2_reg    [3];
    logic signed [MW-1:0]       mul_reg  [NUM_PROD];
    logic signed [MW-1:0]       mul_next [NUM_PROD];
    logic [AW-1:0]              acc_reg  [3];
    logic [AW-1:0]              acc_next [3];
    logic [QVR_OUT_BITS-1:0]    res_reg  [3];
    logic [QVR_OUT_BITS-1:0]    res_next [3];

    // stage handshake: each stage loads when empty or its successor loads
    always_comb
    begin
        rdy[NST-1] = !valid_reg[NST-1] || pop;
        for (int s = NST - 2; s >= 0; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
        for (int s = 0; s < NST; s++)
        begin
            if (rdy[s])
            begin
                valid_next[s] = (s == 0) ? !qstat.empty : valid_reg[(s == 0) ? 0 : s - 1];
            end
            else
            begin
                valid_next[s] = valid_reg[s];
            end
        end
    end

    assign q_pop = !qstat.empty && rdy[0];
    assign empty = !valid_reg[NST-1];
    assign rot_x = res_reg[0];
    assign rot_y = res_reg[1];
    assign rot_z = res_reg[2];

    // unpack queue entry, products sign extended to coefficient width
    always_comb
    begin
        for (int n = 0; n < NUM_PROD; n++)
        begin
            pe[n] = {{(CW-PW){q_data[n*PW + PW - 1]}}, q_data[n*PW +: PW]};
        end
        for (int b = 0; b < 3; b++)
        begin
            vin[b] = q_data[NUM_PROD*PW + b*VEC_BITS +: VEC_BITS];
        end
    end

    // stage 1: raw coefficients in Q6.28 with rounding half already added
    always_comb
    begin
        raw_next[0] = ONE_HALF_C - ((pe[IDX_JJ] + pe[IDX_KK]) << 1);
        raw_next[1] = ((pe[IDX_IJ] - pe[IDX_KR]) << 1) + HALF_C;
        raw_next[2] = ((pe[IDX_IK] + pe[IDX_JR]) << 1) + HALF_C;
        raw_next[3] = ((pe[IDX_IJ] + pe[IDX_KR]) << 1) + HALF_C;
        raw_next[4] = ONE_HALF_C - ((pe[IDX_II] + pe[IDX_KK]) << 1);
        raw_next[5] = ((pe[IDX_JK] - pe[IDX_IR]) << 1) + HALF_C;
        raw_next[6] = ((pe[IDX_IK] - pe[IDX_JR]) << 1) + HALF_C;
        raw_next[7] = ((pe[IDX_JK] + pe[IDX_IR]) << 1) + HALF_C;
        raw_next[8] = ONE_HALF_C - ((pe[IDX_II] + pe[IDX_JJ]) << 1);
    end

    // stage 2: drop fraction bits, clamp to Q2.14
    always_comb
    begin
        logic [SHW-1:0]    sh;
        logic [SHW-QB:0]   hi;
        for (int n = 0; n < NUM_PROD; n++)
        begin
            sh = raw_reg[n][CW-1:F];
            hi = sh[SHW-1:QB-1];
            if (hi == '0 || hi == '1)
            begin
                coef_next[n] = sh[QB-1:0];
            end
            else if (sh[SHW-1])
            begin
                coef_next[n] = {1'b1, {(QB-1){1'b0}}};
            end
            else
            begin
                coef_next[n] = {1'b0, {(QB-1){1'b1}}};
            end
        end
    end

    // stage 3: nine coefficient by component products
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int b = 0; b < 3; b++)
            begin
                mul_next[a*3 + b] = MW'(coef_reg[a*3 + b]) * MW'(v2_reg[b]);
            end
        end
    end

    // stage 4: row sums with rounding half
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            acc_next[a] = {{(AW-MW){mul_reg[a*3][MW-1]}},     mul_reg[a*3]}
                        + {{(AW-MW){mul_reg[a*3 + 1][MW-1]}}, mul_reg[a*3 + 1]}
                        + {{(AW-MW){mul_reg[a*3 + 2][MW-1]}}, mul_reg[a*3 + 2]}
                        + HALF_A;
        end
    end

    // stage 5: shift, then saturate to the output range, or sign extend if the shifted sum is narrower
    generate
        if (RW >= QVR_OUT_BITS)
        begin : g_sat
            always_comb
            begin
                logic [RW-1:0]              sh;
                logic [RW-QVR_OUT_BITS:0]   hi;
                for (int a = 0; a < 3; a++)
                begin
                    sh = acc_reg[a][AW-1:F];
                    hi = sh[RW-1:QVR_OUT_BITS-1];
                    if (hi == '0 || hi == '1)
                    begin
                        res_next[a] = sh[QVR_OUT_BITS-1:0];
                    end
                    else if (sh[RW-1])
                    begin
                        res_next[a] = {1'b1, {(QVR_OUT_BITS-1){1'b0}}};
                    end
                    else
                    begin
                        res_next[a] = {1'b0, {(QVR_OUT_BITS-1){1'b1}}};
                    end
                end
            end
        end
        else
        begin : g_ext
            always_comb
            begin
                for (int a = 0; a < 3; a++)
                begin
                    res_next[a] = {{(QVR_OUT_BITS-RW){acc_reg[a][AW-1]}}, acc_reg[a][AW-1:F]};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int n = 0; n < NUM_PROD; n++)
            begin
                raw_reg[n] <= raw_next[n];
            end
            for (int b = 0; b < 3; b++)
            begin
                v1_reg[b] <= vin[b];
            end
        end
        if (rdy[1])
        begin
            for (int n = 0; n < NUM_PROD; n++)
            begin
                coef_reg[n] <= coef_next[n];
            end
            for (int b = 0; b < 3; b++)
            begin
                v2_reg[b] <= v1_reg[b];
            end
        end
        if (rdy[2])
        begin
            for (int n = 0; n < NUM_PROD; n++)
            begin
                mul_reg[n] <= mul_next[n];
            end
        end
        if (rdy[3])
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= acc_next[a];
            end
        end
        if (rdy[4])
        begin
            for (int a = 0; a < 3; a++)
            begin
                res_reg[a] <= res_next[a];
            end
        end
    end

`ifndef SYNTHESIS
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rot_x) && $stable(rot_y) && $stable(rot_z)))
        else $error("waiting result changed or vanished");
    a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NST-2] && valid_reg[NST-1] && !pop) |=> valid_reg[NST-2])
        else $error("stalled stage dropped its item");
`endif

endmodule
